>>> rtl/bcdtod_pkg.sv
// ----------------------------------------------------------------------------
// BCD time-of-day package
// Shared request and result types, command and register codes, and the
// BCD conversion helpers used by the time-of-day clock.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bcdtod_pkg;

    localparam int DIVIDER_BITS_DEF = 24;
    localparam int TENTH_DIV_W      = 24;
    localparam logic [TENTH_DIV_W-1:0] TENTH_DIV_RESET = 24'd98524;

    // Request commands.
    localparam logic [1:0] CMD_TICK  = 2'd0;
    localparam logic [1:0] CMD_WRITE = 2'd1;
    localparam logic [1:0] CMD_READ  = 2'd2;

    // Register selects.
    localparam logic [2:0] SEL_TENTHS  = 3'd0;
    localparam logic [2:0] SEL_SECONDS = 3'd1;
    localparam logic [2:0] SEL_MINUTES = 3'd2;
    localparam logic [2:0] SEL_HOURS   = 3'd3;
    localparam logic [2:0] SEL_ICR     = 3'd4;

    // Configuration register indexes.
    localparam logic [1:0] CFG_ALARM_SEL = 2'd0;
    localparam logic [1:0] CFG_RUNNING   = 2'd1;
    localparam logic [1:0] CFG_TENTH_DIV = 2'd2;

    // Interrupt flag bit positions.
    localparam int FLAG_TA   = 0;
    localparam int FLAG_TB   = 1;
    localparam int FLAG_ALRM = 2;
    localparam int FLAG_IR   = 7;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] reg_sel;
        logic [7:0] wdata;
        logic       timer_a_event;
        logic       timer_b_event;
    } bcdtod_req_t;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq;
        logic       alarm_hit;
    } bcdtod_rsp_t;

    typedef struct packed {
        logic                   alarm_sel;
        logic                   running;
        logic [TENTH_DIV_W-1:0] tenth_div;
    } bcdtod_cfg_t;

    typedef struct packed {
        logic [3:0] tenths;
        logic [6:0] seconds;
        logic [6:0] minutes;
        logic [7:0] hours;
    } bcdtod_tod_t;

    // Two digits read as high * 10 + low, whatever their values.
    function automatic logic [6:0] from_bcd(input logic [6:0] b);
        return 7'(b[6:4]) * 7'd10 + 7'(b[3:0]);
    endfunction

    // Binary to two BCD digits; the quotient by ten is a reciprocal
    // multiply, exact for every 7-bit value.
    function automatic logic [7:0] to_bcd(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  q;
        logic [6:0]  r;
        prod = 15'(v) * 15'd205;
        q    = prod[14:11];
        r    = v - 7'(q) * 7'd10;
        return {q, r[3:0]};
    endfunction

endpackage

>>> rtl/bcdtod_time.sv
// ----------------------------------------------------------------------------
// BCD time-of-day counter
// Holds the clock and alarm times and the tenth-second countdown, advances
// the time on ticks and flags a match with the alarm.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcdtod_time
    import bcdtod_pkg::*;
#(
    parameter int DIVIDER_BITS = DIVIDER_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  bcdtod_req_t req,
    input  bcdtod_cfg_t cfg,
    output bcdtod_tod_t tod,
    output logic        hit
);

    localparam int RELOAD_W = (DIVIDER_BITS < TENTH_DIV_W) ? DIVIDER_BITS : TENTH_DIV_W;

    bcdtod_tod_t             tod_reg, tod_next;
    bcdtod_tod_t             alarm_reg, alarm_next;
    logic [DIVIDER_BITS-1:0] count_reg, count_next;
    logic [DIVIDER_BITS-1:0] reload;
    bcdtod_tod_t             adv;
    logic [3:0]              t_inc;
    logic [6:0]              s_bin, m_bin, h_bin, h_val, pm_off;
    logic [7:0]              s_bcd, m_bcd, h_bcd;
    logic                    pm_next;

    assign reload = DIVIDER_BITS'(cfg.tenth_div[RELOAD_W-1:0]);

    // Time after one tenth step.
    always_comb
    begin
        adv     = tod_reg;
        t_inc   = tod_reg.tenths + 4'd1;
        s_bin   = from_bcd(tod_reg.seconds) + 7'd1;
        m_bin   = from_bcd(tod_reg.minutes) + 7'd1;
        pm_off  = tod_reg.hours[7] ? 7'd12 : 7'd0;
        h_bin   = from_bcd({2'b00, tod_reg.hours[4:0]}) + pm_off + 7'd1;
        pm_next = tod_reg.hours[7];
        h_val   = h_bin - pm_off;
        if (h_bin == 7'd24)
        begin
            pm_next = 1'b0;
            h_val   = 7'd0;
        end
        else if (h_bin == 7'd12)
        begin
            pm_next = 1'b1;
            h_val   = 7'd0;
        end
        s_bcd = to_bcd(s_bin);
        m_bcd = to_bcd(m_bin);
        h_bcd = to_bcd(h_val);
        adv.tenths = t_inc;
        if (t_inc == 4'd10)
        begin
            adv.tenths = 4'd0;
            if (s_bin == 7'd60)
            begin
                adv.seconds = 7'd0;
                if (m_bin == 7'd60)
                begin
                    adv.minutes = 7'd0;
                    adv.hours   = ({pm_next, 7'b0} | h_bcd) & 8'h9F;
                end
                else
                begin
                    adv.minutes = m_bcd[6:0];
                end
            end
            else
            begin
                adv.seconds = s_bcd[6:0];
            end
        end
    end

    always_comb
    begin
        tod_next   = tod_reg;
        alarm_next = alarm_reg;
        count_next = count_reg;
        hit        = 1'b0;
        case (req.cmd)
            CMD_TICK:
            begin
                if (cfg.running)
                begin
                    if (count_reg == '0)
                    begin
                        tod_next   = adv;
                        count_next = reload;
                        hit        = (adv == alarm_reg);
                    end
                    else
                    begin
                        count_next = count_reg - DIVIDER_BITS'(1);
                    end
                end
            end
            CMD_WRITE:
            begin
                case (req.reg_sel)
                    SEL_TENTHS:
                    begin
                        if (cfg.alarm_sel) alarm_next.tenths = req.wdata[3:0];
                        else               tod_next.tenths   = req.wdata[3:0];
                    end
                    SEL_SECONDS:
                    begin
                        if (cfg.alarm_sel) alarm_next.seconds = req.wdata[6:0];
                        else               tod_next.seconds   = req.wdata[6:0];
                    end
                    SEL_MINUTES:
                    begin
                        if (cfg.alarm_sel) alarm_next.minutes = req.wdata[6:0];
                        else               tod_next.minutes   = req.wdata[6:0];
                    end
                    SEL_HOURS:
                    begin
                        if (cfg.alarm_sel) alarm_next.hours = req.wdata & 8'h9F;
                        else               tod_next.hours   = req.wdata & 8'h9F;
                    end
                    default:
                    begin
                    end
                endcase
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tod_reg   <= '0;
            alarm_reg <= '0;
            count_reg <= '0;
        end
        else if (fire)
        begin
            tod_reg   <= tod_next;
            alarm_reg <= alarm_next;
            count_reg <= count_next;
        end
    end

    assign tod = tod_reg;

endmodule

>>> rtl/bcdtod_intc.sv
// ----------------------------------------------------------------------------
// Interrupt control
// Collects timer and alarm flags, keeps the source mask and drives the
// interrupt line; a read of the control register clears the flags and the line.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcdtod_intc
    import bcdtod_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        fire,
    input  bcdtod_req_t req,
    input  logic        hit,
    output logic [7:0]  flags,
    output logic        irq
);

    logic [7:0] flags_reg, flags_next;
    logic [4:0] mask_reg, mask_next;
    logic       irq_reg, irq_next;

    always_comb
    begin
        flags_next = flags_reg;
        mask_next  = mask_reg;
        irq_next   = irq_reg;
        case (req.cmd)
            CMD_TICK:
            begin
                flags_next[FLAG_TA]   = flags_reg[FLAG_TA] | req.timer_a_event;
                flags_next[FLAG_TB]   = flags_reg[FLAG_TB] | req.timer_b_event;
                flags_next[FLAG_ALRM] = flags_reg[FLAG_ALRM] | hit;
                // IR is only raised from clear, so a pending request stays as is.
                if (!flags_next[FLAG_IR] && ((flags_next[4:0] & mask_reg) != '0))
                begin
                    flags_next[FLAG_IR] = 1'b1;
                    irq_next            = 1'b1;
                end
            end
            CMD_WRITE:
            begin
                if (req.reg_sel == SEL_ICR)
                begin
                    if (req.wdata[7]) mask_next = mask_reg | req.wdata[4:0];
                    else              mask_next = mask_reg & ~req.wdata[4:0];
                end
            end
            CMD_READ:
            begin
                if (req.reg_sel == SEL_ICR)
                begin
                    flags_next = '0;
                    irq_next   = 1'b0;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
            mask_reg  <= '0;
            irq_reg   <= 1'b0;
        end
        else if (fire)
        begin
            flags_reg <= flags_next;
            mask_reg  <= mask_next;
            irq_reg   <= irq_next;
        end
    end

    assign flags = flags_reg;
    assign irq   = irq_next;

endmodule

>>> rtl/bcd_time_of_day_clock_with_alarm_irq_unit.sv
// ----------------------------------------------------------------------------
// BCD time-of-day clock with alarm and interrupt control
// Throughput: one request per cycle while out_stall is low; the counter and
// interrupt logic sit between an input register and a result register.
// Reset clears the time, alarm, countdown, flags and mask; the clock runs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bcd_time_of_day_clock_with_alarm_irq_unit
    import bcdtod_pkg::*;
#(
    parameter int DIVIDER_BITS = DIVIDER_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  bcdtod_req_t            in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output bcdtod_rsp_t            out_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [TENTH_DIV_W-1:0] cfg_data
);

    logic        in_valid_reg;
    bcdtod_req_t in_data_reg;
    logic        out_valid_reg;
    bcdtod_rsp_t out_data_reg;
    bcdtod_cfg_t cfg_reg;
    logic        fire;
    bcdtod_tod_t tod;
    logic        hit;
    logic [7:0]  flags;
    logic        irq;
    bcdtod_rsp_t rsp;

    // A request is processed when the result register is free or draining.
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alarm_sel <= 1'b0;
            cfg_reg.running   <= 1'b1;
            cfg_reg.tenth_div <= TENTH_DIV_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_ALARM_SEL: cfg_reg.alarm_sel <= cfg_data[0];
                CFG_RUNNING:   cfg_reg.running   <= cfg_data[0];
                CFG_TENTH_DIV: cfg_reg.tenth_div <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    bcdtod_time #(
        .DIVIDER_BITS (DIVIDER_BITS)
    ) u_time (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (in_data_reg),
        .cfg   (cfg_reg),
        .tod   (tod),
        .hit   (hit)
    );

    bcdtod_intc u_intc (
        .clk   (clk),
        .rst_n (rst_n),
        .fire  (fire),
        .req   (in_data_reg),
        .hit   (hit),
        .flags (flags),
        .irq   (irq)
    );

    always_comb
    begin
        rsp.rdata     = '0;
        rsp.irq       = irq;
        rsp.alarm_hit = hit;
        if (in_data_reg.cmd == CMD_READ)
        begin
            case (in_data_reg.reg_sel)
                SEL_TENTHS:  rsp.rdata = {4'b0, tod.tenths};
                SEL_SECONDS: rsp.rdata = {1'b0, tod.seconds};
                SEL_MINUTES: rsp.rdata = {1'b0, tod.minutes};
                SEL_HOURS:   rsp.rdata = tod.hours;
                SEL_ICR:     rsp.rdata = flags;
                default:     rsp.rdata = '0;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            out_data_reg <= rsp;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // The interrupt line and the IR flag are raised and cleared together.
    assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> (u_intc.irq_reg == flags[FLAG_IR]))
        else $error("irq line and IR flag disagree");

    // An alarm match on a tick leaves the alarm flag set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_data_reg.cmd == CMD_TICK && hit) |=> flags[FLAG_ALRM])
        else $error("alarm match did not set the alarm flag");

    // Reading the control register clears all flags.
    assert property (@(posedge clk) disable iff (!rst_n)
        (fire && in_data_reg.cmd == CMD_READ && in_data_reg.reg_sel == SEL_ICR)
        |=> (flags == '0))
        else $error("control register read did not clear flags");

    // The time only moves when a request is processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(tod))
        else $error("time changed without a request");

endmodule
